>>> design/phdva_pkg.sv
// Shared types, constants and codes for the piezo hit detector with voice assignment.
// No dependencies; every other design file imports this package.

package phdva_pkg;

   localparam int NUM_VOICES = 8;
   localparam int ADC_BITS   = 10;
   localparam int STAMP_BITS = 32;

   localparam int BUSY_W   = 8;
   localparam int THR_W    = 10;
   localparam int VEL_W    = 11;
   localparam int SGAIN_W  = 12;
   localparam int SEL_W    = 8;
   localparam int GAIN_W   = 22;
   localparam int VGAIN_W  = 22;
   localparam int VOICE_W  = 3;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam int VID_W   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int SCAN_W  = $clog2(NUM_VOICES + 1);
   localparam int VOX_W   = (VID_W > VOICE_W) ? VID_W : VOICE_W;
   localparam int BUSYX_W = (NUM_VOICES > BUSY_W) ? NUM_VOICES : BUSY_W;
   localparam int CMP_W   = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
   localparam int ADCX_W  = (ADC_BITS > 11) ? ADC_BITS : 11;

   localparam int PEAK_CLAMP = 1024;
   localparam int Q10_ONE    = 1024;
   localparam int Q10_SHIFT  = 10;

   localparam int Q_DEPTH = 2;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_RISE_THR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FALL_THR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_SENS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SMP_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SMP_SEL   = 3'd4;

   localparam logic [THR_W-1:0]   RISE_THR_RST = 10'd50;
   localparam logic [THR_W-1:0]   FALL_THR_RST = 10'd40;
   localparam logic [VEL_W-1:0]   VEL_SENS_RST = 11'd1024;
   localparam logic [SGAIN_W-1:0] SMP_GAIN_RST = 12'd1024;
   localparam logic [SEL_W-1:0]   SMP_SEL_RST  = 8'd0;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RISE,
      PH_FALL
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_SAT,
      BK_VGAIN,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic [THR_W-1:0]   rise_threshold;
      logic [THR_W-1:0]   fall_threshold;
      logic [VEL_W-1:0]   velocity_sensitivity;
      logic [SGAIN_W-1:0] sample_gain;
      logic [SEL_W-1:0]   sample_select;
   } cfg_type;

   typedef struct packed {
      logic                hit;
      logic [ADC_BITS-1:0] adc;
      logic [BUSY_W-1:0]   busy;
   } item_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_status_type;

endpackage

>>> design/phdva_front.sv
// Front end: accepts sample transactions, runs the idle/rise/fall phase machine
// and classifies each sample as hit or no hit. Uses phdva_pkg.

module phdva_front import phdva_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   input  logic [ADC_BITS-1:0] req_adc_value,
   input  logic [BUSY_W-1:0]   req_voice_busy,
   input  logic                q_full,
   output logic                req_ready,
   output logic                push,
   output item_type            push_item
);

   phase_type           phase_ff, phase_in;
   logic [ADC_BITS-1:0] prev_ff, prev_in;
   logic                accept;
   logic                hit;
   logic [CMP_W-1:0]    adc_x, prev_x, rise_x, fall_x;
   phase_type           ph_a, ph_b;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign adc_x  = CMP_W'(req_adc_value);
   assign prev_x = CMP_W'(prev_ff);
   assign rise_x = CMP_W'(cfg.rise_threshold);
   assign fall_x = CMP_W'(cfg.fall_threshold);

   // next phase: all three checks may fire on the same sample
   always_comb begin
      ph_a = phase_ff;
      if (ph_a == PH_IDLE && adc_x > rise_x) begin
         ph_a = PH_RISE;
      end
      ph_b = ph_a;
      if (ph_a == PH_RISE && adc_x < prev_x) begin
         ph_b = PH_FALL;
      end
      phase_in = phase_ff;
      prev_in  = prev_ff;
      if (accept) begin
         prev_in  = req_adc_value;
         phase_in = ph_b;
         if (ph_b == PH_FALL && adc_x < fall_x) begin
            phase_in = PH_IDLE;
         end
      end
   end

   // outputs: hit classification
   always_comb begin
      hit = 1'b0;
      if ((phase_ff == PH_RISE || (phase_ff == PH_IDLE && adc_x > rise_x)) &&
          adc_x < prev_x) begin
         hit = 1'b1;
      end
      push           = accept;
      push_item.hit  = hit;
      push_item.adc  = req_adc_value;
      push_item.busy = req_voice_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         prev_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

>>> design/phdva_queue.sv
// Two-entry transaction queue between the front and back ends.
// Uses phdva_pkg for the item type and depth.

module phdva_queue import phdva_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  item_type     push_item,
   input  logic         pop,
   output item_type     head,
   output q_status_type status
);

   item_type           mem_ff [Q_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == QCNT_W'(Q_DEPTH));
   assign status.valid = (count_ff != '0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/phdva_back.sv
// Back end: gain arithmetic, voice choice with oldest-stamp search, stamp
// bookkeeping and the result register. Uses phdva_pkg.

module phdva_back import phdva_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  q_status_type               q_status,
   input  item_type                   q_head,
   output logic                       pop,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic signed [GAIN_W-1:0]   rsp_hit_gain,
   output logic [VOICE_W-1:0]         rsp_voice,
   output logic                       rsp_stolen,
   output logic [VGAIN_W-1:0]         rsp_voice_gain,
   output logic [SEL_W-1:0]           rsp_sample_id
);

   back_state_type state_ff, state_in;

   logic [ADC_BITS-1:0]   adc_ff;
   logic [BUSY_W-1:0]     busy_ff;

   logic signed [23:0]    prod1_ff;
   logic signed [GAIN_W-1:0] g_ff;
   logic [32:0]           prod2_ff;

   logic [STAMP_BITS-1:0] stamp_ff [NUM_VOICES];
   logic [STAMP_BITS-1:0] stamp_cnt_ff;
   logic [SCAN_W-1:0]     scan_idx_ff;
   logic [STAMP_BITS-1:0] low_ff;
   logic [VID_W-1:0]      oldest_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  hit_ff;
   logic signed [GAIN_W-1:0] hit_gain_ff;
   logic [VOICE_W-1:0]    voice_ff;
   logic                  stolen_ff;
   logic [VGAIN_W-1:0]    vgain_ff;
   logic [SEL_W-1:0]      sample_id_ff;

   logic out_free, scan_done, scan_run, load_zero, commit, start_hit;

   // arithmetic
   logic [ADCX_W-1:0]     adc_x;
   logic [10:0]           adc_clamp;
   logic signed [11:0]    peak;
   logic signed [11:0]    vel_s;
   logic signed [12:0]    fixed_term;
   logic signed [24:0]    gain_sum;
   logic signed [GAIN_W-1:0] gain_sat;
   logic [20:0]           g_pos;
   logic [22:0]           vg_raw;
   logic [VGAIN_W-1:0]    vg_sat;

   // voice choice
   logic [BUSYX_W-1:0]    busy_x;
   logic                  any_idle;
   logic [VID_W-1:0]      chosen_idle;
   logic [VID_W-1:0]      final_voice;
   logic [VOX_W-1:0]      final_voice_x;
   logic [STAMP_BITS-1:0] scan_stamp;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_done = (scan_idx_ff == SCAN_W'(NUM_VOICES));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_status.valid && q_head.hit) begin
               state_in = BK_MUL;
            end
         end
         BK_MUL:    state_in = BK_SAT;
         BK_SAT:    state_in = BK_VGAIN;
         BK_VGAIN:  state_in = BK_FINISH;
         BK_FINISH: begin
            if (scan_done && out_free) begin
               state_in = BK_IDLE;
            end
         end
         default:   state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop       = 1'b0;
      load_zero = 1'b0;
      commit    = 1'b0;
      start_hit = 1'b0;
      scan_run  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            start_hit = q_status.valid && q_head.hit;
            load_zero = q_status.valid && !q_head.hit && out_free;
            pop       = start_hit || load_zero;
         end
         BK_FINISH: begin
            commit   = scan_done && out_free;
            scan_run = !scan_done;
         end
         default: begin
            scan_run = !scan_done;
         end
      endcase
   end

   // hit gain: fixed part plus peak-proportional part, then saturate
   always_comb begin
      adc_x      = ADCX_W'(adc_ff);
      adc_clamp  = (adc_x > ADCX_W'(PEAK_CLAMP)) ? 11'(PEAK_CLAMP) : adc_x[10:0];
      peak       = $signed({1'b0, adc_clamp}) - $signed({2'b00, cfg.rise_threshold});
      vel_s      = $signed({1'b0, cfg.velocity_sensitivity});
      fixed_term = 13'(Q10_ONE) - $signed({2'b00, cfg.velocity_sensitivity});
      gain_sum   = $signed({{2{fixed_term[12]}}, fixed_term, 10'b0})
                 + $signed({prod1_ff[23], prod1_ff});
      if (gain_sum > 25'sd2097151) begin
         gain_sat = 22'sh1FFFFF;
      end else if (gain_sum < -25'sd2097152) begin
         gain_sat = 22'sh200000;
      end else begin
         gain_sat = gain_sum[GAIN_W-1:0];
      end
      g_pos  = (g_ff > 22'sd0) ? g_ff[20:0] : '0;
      vg_raw = prod2_ff[32:Q10_SHIFT];
      vg_sat = vg_raw[22] ? '1 : vg_raw[VGAIN_W-1:0];
   end

   // highest-numbered idle voice; voices beyond the busy mask count as idle
   always_comb begin
      busy_x      = BUSYX_W'(busy_ff);
      any_idle    = 1'b0;
      chosen_idle = '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
         if (!busy_x[i]) begin
            any_idle    = 1'b1;
            chosen_idle = VID_W'(i);
         end
      end
      final_voice   = any_idle ? chosen_idle : oldest_ff;
      final_voice_x = VOX_W'(final_voice);
      scan_stamp    = stamp_ff[scan_idx_ff[VID_W-1:0]];
   end

   assign rsp_valid_in = load_zero || commit || (rsp_valid_ff && !rsp_ready);

   // datapath registers, free running
   always_ff @(posedge clock) begin
      prod1_ff <= 24'(peak * vel_s);
      g_ff     <= gain_sat;
      prod2_ff <= 33'(g_pos * cfg.sample_gain);
      if (pop) begin
         adc_ff  <= q_head.adc;
         busy_ff <= q_head.busy;
      end
      if (start_hit) begin
         low_ff    <= stamp_ff[0];
         oldest_ff <= '0;
      end else if (scan_run && scan_stamp < low_ff) begin
         low_ff    <= scan_stamp;
         oldest_ff <= scan_idx_ff[VID_W-1:0];
      end
      if (load_zero) begin
         hit_ff       <= 1'b0;
         hit_gain_ff  <= '0;
         voice_ff     <= '0;
         stolen_ff    <= 1'b0;
         vgain_ff     <= '0;
         sample_id_ff <= '0;
      end else if (commit) begin
         hit_ff       <= 1'b1;
         hit_gain_ff  <= g_ff;
         voice_ff     <= final_voice_x[VOICE_W-1:0];
         stolen_ff    <= !any_idle;
         vgain_ff     <= vg_sat;
         sample_id_ff <= cfg.sample_select;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         scan_idx_ff  <= SCAN_W'(NUM_VOICES);
         stamp_cnt_ff <= '0;
         for (int i = 0; i < NUM_VOICES; i++) begin
            stamp_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (start_hit) begin
            scan_idx_ff <= SCAN_W'(1);
         end else if (scan_run) begin
            scan_idx_ff <= scan_idx_ff + 1'b1;
         end
         if (commit) begin
            stamp_ff[final_voice] <= stamp_cnt_ff;
            stamp_cnt_ff          <= stamp_cnt_ff + 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = hit_ff;
   assign rsp_hit_gain   = hit_gain_ff;
   assign rsp_voice      = voice_ff;
   assign rsp_stolen     = stolen_ff;
   assign rsp_voice_gain = vgain_ff;
   assign rsp_sample_id  = sample_id_ff;

endmodule

>>> design/piezo_hit_detect_voice_assign.sv
// Top level of the piezo hit detector with voice assignment: csr registers,
// front end, queue and back end. Uses phdva_pkg, phdva_front, phdva_queue, phdva_back.
//
// One sample transaction in, one result transaction out. The front end takes a
// sample every cycle while the two-entry queue has room. In the back end a
// sample with no hit is answered from IDLE; a hit steps through MUL, SAT, VGAIN
// and FINISH, leaving FINISH once the oldest-stamp search, which compares one
// voice stamp per cycle while the two gain multiplies run alongside it, is done.
// The result sits in an output register, so a following hit starts while it waits.
// csr writes are taken every cycle and must only happen while the block is idle.

module piezo_hit_detect_voice_assign import phdva_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ADC_BITS-1:0]        req_adc_value,
   input  logic [BUSY_W-1:0]          req_voice_busy,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_hit,
   output logic signed [GAIN_W-1:0]   rsp_hit_gain,
   output logic [VOICE_W-1:0]         rsp_voice,
   output logic                       rsp_stolen,
   output logic [VGAIN_W-1:0]         rsp_voice_gain,
   output logic [SEL_W-1:0]           rsp_sample_id,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   q_status_type q_status;
   item_type     push_item, q_head;
   logic         push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RISE_THR: cfg_in.rise_threshold       = csr_wdata[THR_W-1:0];
            REG_FALL_THR: cfg_in.fall_threshold       = csr_wdata[THR_W-1:0];
            REG_VEL_SENS: cfg_in.velocity_sensitivity = csr_wdata[VEL_W-1:0];
            REG_SMP_GAIN: cfg_in.sample_gain          = csr_wdata[SGAIN_W-1:0];
            REG_SMP_SEL:  cfg_in.sample_select        = csr_wdata[SEL_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_threshold       <= RISE_THR_RST;
         cfg_ff.fall_threshold       <= FALL_THR_RST;
         cfg_ff.velocity_sensitivity <= VEL_SENS_RST;
         cfg_ff.sample_gain          <= SMP_GAIN_RST;
         cfg_ff.sample_select        <= SMP_SEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   phdva_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_adc_value  (req_adc_value),
      .req_voice_busy (req_voice_busy),
      .q_full         (q_status.full),
      .req_ready      (req_ready),
      .push           (push),
      .push_item      (push_item)
   );

   phdva_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (q_head),
      .status    (q_status)
   );

   phdva_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_status       (q_status),
      .q_head         (q_head),
      .pop            (pop),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_hit        (rsp_hit),
      .rsp_hit_gain   (rsp_hit_gain),
      .rsp_voice      (rsp_voice),
      .rsp_stolen     (rsp_stolen),
      .rsp_voice_gain (rsp_voice_gain),
      .rsp_sample_id  (rsp_sample_id)
   );

   a_nohit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_gain == '0 && rsp_voice_gain == '0 &&
                                rsp_voice == '0 && !rsp_stolen && rsp_sample_id == '0)
      else $error("no-hit transaction carries non-zero fields");

   a_neg_gain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit && rsp_hit_gain <= 22'sd0 |-> rsp_voice_gain == '0)
      else $error("voice gain not clamped for non-positive hit gain");

   a_steal_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stolen |-> rsp_hit)
      else $error("steal flagged without a hit");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_status.valid)
      else $error("queue popped while empty");

endmodule
